>>> src/pskr_pkg.sv
package pskr_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 4096;
    localparam int unsigned TABLE_WAYS_DEF    = 4;
    localparam int unsigned COUNT_BITS_DEF    = 16;

    localparam logic [63:0] WINDOW_RST   = 64'd1000000000;
    localparam logic [15:0] KNOCKS_RST   = 16'd8;
    localparam logic [15:0] SESSIONS_RST = 16'd4;

    localparam logic [31:0] HASH_MUL = 32'h045D9F3B;

    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_KNOCKS   = 2'd1;
    localparam logic [1:0] CFG_SESSIONS = 2'd2;

    typedef enum logic [1:0] {
        CMD_KNOCK   = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VER_OK    = 2'd0,
        VER_RATE  = 2'd1,
        VER_SESS  = 2'd2,
        VER_EMPTY = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] source_address;
        logic [63:0] time_now_ns;
    } t_req;

    typedef struct packed {
        logic [63:0] window_length_ns;
        logic [15:0] max_knocks_per_window;
        logic [15:0] max_sessions_per_source;
    } t_cfg;

endpackage

>>> src/pskr_if.sv
interface pskr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] source_address;
    logic [63:0] time_now_ns;

    modport source (output valid, command, source_address, time_now_ns, input ready);
    modport sink (input valid, command, source_address, time_now_ns, output ready);
endinterface

interface pskr_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [1:0]  verdict;
    logic [15:0] knock_count_now;
    logic [15:0] sessions_now;

    modport source (output valid, allowed, verdict, knock_count_now, sessions_now, input ready);
    modport sink (input valid, allowed, verdict, knock_count_now, sessions_now, output ready);
endinterface

>>> src/pskr_ram.sv
module pskr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pskr_fifo.sv
module pskr_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push_ok      = i_push && o_push_ready;
    assign pop_ok       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

>>> src/pskr_front.sv
module pskr_front import pskr_pkg::*; #(
    parameter int unsigned SET_COUNT = TABLE_ENTRIES_DEF / TABLE_WAYS_DEF,
    parameter int unsigned SET_BITS  = $clog2(TABLE_ENTRIES_DEF / TABLE_WAYS_DEF)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_hold,
    pskr_req_if.sink            i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output t_req                o_req,
    output logic [SET_BITS-1:0] o_set
);

    localparam int unsigned R_BITS = SET_BITS + 2;
    localparam logic [63:0] RECIP64 = (64'd1 << 32) / SET_COUNT;
    localparam logic [31:0] RECIP = RECIP64[31:0];
    localparam logic [31:0] DIV = 32'(SET_COUNT);
    localparam logic [R_BITS-1:0] D1 = R_BITS'(SET_COUNT);
    localparam logic [R_BITS-1:0] D2 = R_BITS'(2 * SET_COUNT);

    logic r_v1, r_v2, r_v3, r_v4;
    t_req r_req1, r_req2, r_req3, r_req4;
    logic [31:0] r_m1, r_h2, r_p2;
    logic [R_BITS-1:0] r_r3;
    logic [SET_BITS-1:0] r_set4;

    logic adv;
    logic take;
    logic [31:0] x1;
    logic [31:0] h2;
    logic [63:0] prod2;
    logic [31:0] qd3;
    logic [31:0] r3;
    logic [R_BITS-1:0] set4;
    t_req in_req;

    assign adv         = !r_v4 || i_ready;
    assign i_req.ready = adv && !i_hold;
    assign take        = i_req.valid && !i_hold;

    assign in_req.command        = i_req.command;
    assign in_req.source_address = i_req.source_address;
    assign in_req.time_now_ns    = i_req.time_now_ns;

    assign x1    = i_req.source_address ^ (i_req.source_address >> 16);
    assign h2    = r_m1 ^ (r_m1 >> 16);
    assign prod2 = 64'(h2) * 64'(RECIP);
    assign qd3   = r_p2 * DIV;
    assign r3    = r_h2 - qd3;

    always_comb begin
        if (r_r3 >= D2) begin
            set4 = r_r3 - D2;
        end else if (r_r3 >= D1) begin
            set4 = r_r3 - D1;
        end else begin
            set4 = r_r3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req1 <= in_req;
            r_m1   <= x1 * HASH_MUL;
            r_req2 <= r_req1;
            r_h2   <= h2;
            r_p2   <= prod2[63:32];
            r_req3 <= r_req2;
            r_r3   <= r3[R_BITS-1:0];
            r_req4 <= r_req3;
            r_set4 <= set4[SET_BITS-1:0];
        end
    end

    assign o_valid = r_v4;
    assign o_req   = r_req4;
    assign o_set   = r_set4;

endmodule

>>> src/pskr_back.sv
module pskr_back import pskr_pkg::*; #(
    parameter int unsigned TABLE_WAYS = TABLE_WAYS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
    parameter int unsigned SET_COUNT  = TABLE_ENTRIES_DEF / TABLE_WAYS_DEF,
    parameter int unsigned SET_BITS   = $clog2(TABLE_ENTRIES_DEF / TABLE_WAYS_DEF)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    input  t_req                i_req,
    input  logic [SET_BITS-1:0] i_set,
    output logic                o_pop,
    output logic                o_busy,
    pskr_rsp_if.source          o_rsp
);

    localparam int unsigned WAY_BITS = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int unsigned CW = COUNT_BITS;
    localparam logic [31:0] COUNT_MAX = 32'hFFFFFFFF >> (32 - COUNT_BITS);

    typedef struct packed {
        logic          valid;
        logic [31:0]   addr;
        logic [63:0]   start;
        logic [CW-1:0] knocks;
        logic [CW-1:0] sessions;
    } t_entry;

    typedef struct packed {
        t_entry [TABLE_WAYS-1:0]                ways;
        logic   [TABLE_WAYS-1:0][WAY_BITS-1:0]  order;
    } t_row;

    localparam int unsigned ROW_W = $bits(t_row);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state              r_state;
    logic [SET_BITS-1:0] r_clr;
    t_req                r_req;
    logic [SET_BITS-1:0] r_set;
    logic                r_out_valid;
    logic                r_allowed;
    t_verdict            r_verdict;
    logic [15:0]         r_knocks;
    logic [15:0]         r_sessions;

    logic [ROW_W-1:0]    rd_bits;
    t_row                rd_row;
    t_row                wr_row;
    t_row                clr_row;
    logic                we;
    logic [SET_BITS-1:0] waddr;

    t_cmd                cmd;
    logic [TABLE_WAYS-1:0] hit;
    logic                any_hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] tgt;
    logic [WAY_BITS-1:0] pos;
    t_entry              sel;
    t_entry              n_ent;
    logic [63:0]         elapsed;
    logic                expired;
    logic [CW-1:0]       ck;
    logic [31:0]         kl32;
    logic [31:0]         sl32;
    logic [CW-1:0]       klim;
    logic [CW-1:0]       slim;
    logic                upd;
    logic                touch;
    logic                n_allowed;
    t_verdict            n_verdict;
    logic [CW-1:0]       n_knocks;
    logic [CW-1:0]       n_sessions;
    logic                pop_ok;

    pskr_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (we && r_state == S_CLEAR ? clr_row : wr_row),
        .i_raddr (i_set),
        .o_rdata (rd_bits)
    );

    assign rd_row = t_row'(rd_bits);

    assign pop_ok = (r_state == S_IDLE) && i_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop  = pop_ok;
    assign o_busy = (r_state == S_CLEAR);

    always_comb begin
        clr_row = '0;
        for (int k = 0; k < TABLE_WAYS; k++) begin
            clr_row.order[k] = WAY_BITS'(k);
        end
    end

    assign cmd     = t_cmd'(r_req.command);
    assign kl32    = {16'b0, i_cfg.max_knocks_per_window};
    assign sl32    = {16'b0, i_cfg.max_sessions_per_source};
    assign klim    = (kl32 > COUNT_MAX) ? COUNT_MAX[CW-1:0] : kl32[CW-1:0];
    assign slim    = (sl32 > COUNT_MAX) ? COUNT_MAX[CW-1:0] : sl32[CW-1:0];

    always_comb begin
        hit      = '0;
        hit_way  = '0;
        sel      = '0;
        free_way = rd_row.order[TABLE_WAYS-1];
        for (int w = 0; w < TABLE_WAYS; w++) begin
            hit[w] = rd_row.ways[w].valid && (rd_row.ways[w].addr == r_req.source_address);
        end
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            if (hit[w]) begin
                hit_way = WAY_BITS'(w);
                sel     = rd_row.ways[w];
            end
            if (!rd_row.ways[w].valid) begin
                free_way = WAY_BITS'(w);
            end
        end
    end

    assign any_hit = |hit;
    assign elapsed = r_req.time_now_ns - sel.start;
    assign expired = !any_hit || (elapsed >= i_cfg.window_length_ns);
    assign ck      = expired ? '0 : sel.knocks;

    always_comb begin
        n_ent       = sel;
        n_ent.valid = 1'b1;
        n_ent.addr  = r_req.source_address;
        upd         = 1'b0;
        n_allowed   = 1'b0;
        n_verdict   = VER_OK;
        n_knocks    = sel.knocks;
        n_sessions  = sel.sessions;
        unique case (cmd)
            CMD_KNOCK: begin
                if (ck >= klim) begin
                    n_verdict = VER_RATE;
                end else begin
                    n_ent.start  = expired ? r_req.time_now_ns : sel.start;
                    n_ent.knocks = ck + 1'b1;
                    upd          = 1'b1;
                    n_allowed    = 1'b1;
                    n_knocks     = ck + 1'b1;
                end
            end
            CMD_RESERVE: begin
                if (sel.sessions >= slim) begin
                    n_verdict = VER_SESS;
                end else begin
                    n_ent.sessions = sel.sessions + 1'b1;
                    upd            = 1'b1;
                    n_allowed      = 1'b1;
                    n_sessions     = sel.sessions + 1'b1;
                end
            end
            CMD_RELEASE: begin
                n_allowed = 1'b1;
                if (!any_hit || sel.sessions == '0) begin
                    n_verdict = VER_EMPTY;
                end else begin
                    n_ent.sessions = sel.sessions - 1'b1;
                    upd            = 1'b1;
                    n_sessions     = sel.sessions - 1'b1;
                end
            end
            CMD_NONE: begin
                n_knocks   = '0;
                n_sessions = '0;
            end
            default: begin
                n_knocks   = '0;
                n_sessions = '0;
            end
        endcase
    end

    assign tgt   = any_hit ? hit_way : free_way;
    assign touch = (cmd != CMD_NONE) && (any_hit || upd);

    always_comb begin
        wr_row = rd_row;
        pos    = WAY_BITS'(TABLE_WAYS - 1);
        if (upd) begin
            wr_row.ways[tgt] = n_ent;
        end
        for (int k = TABLE_WAYS - 1; k >= 0; k--) begin
            if (rd_row.order[k] == tgt) begin
                pos = WAY_BITS'(k);
            end
        end
        if (touch) begin
            for (int k = 0; k < TABLE_WAYS; k++) begin
                if (k == 0) begin
                    wr_row.order[k] = tgt;
                end else if (WAY_BITS'(k) <= pos) begin
                    wr_row.order[k] = rd_row.order[k-1];
                end
            end
        end
    end

    assign we    = (r_state == S_CLEAR) || ((r_state == S_EXEC) && (cmd != CMD_NONE));
    assign waddr = (r_state == S_CLEAR) ? r_clr : r_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SET_BITS'(SET_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop_ok) begin
                        r_req   <= i_req;
                        r_set   <= i_set;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_allowed   <= n_allowed;
                    r_verdict   <= n_verdict;
                    r_knocks    <= 16'(32'(n_knocks));
                    r_sessions  <= 16'(32'(n_sessions));
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.allowed         = r_allowed;
    assign o_rsp.verdict         = r_verdict;
    assign o_rsp.knock_count_now = r_knocks;
    assign o_rsp.sessions_now    = r_sessions;

endmodule

>>> src/per_source_knock_rate_table.sv
// Channel  | Dir | Transfer when          | Payload
// i_req    | in  | valid && ready         | command, source_address, time_now_ns
// o_rsp    | out | valid && ready         | allowed, verdict, knock_count_now, sessions_now
// i_cfg_*  | in  | i_cfg_we               | register index, 64-bit data
//
// The table engine takes one request at a time: one row read, then one row update,
// both on the single set-row RAM. Hashing is done in a register pipeline in front.
// After reset a clearing pass writes every set row (TABLE_ENTRIES/TABLE_WAYS rows,
// 1024 by default); i_req.ready stays low meanwhile.
// A 2-deep queue and the result register let the front keep taking transfers
// while a result waits on o_rsp.ready.
module per_source_knock_rate_table import pskr_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned TABLE_WAYS    = TABLE_WAYS_DEF,
    parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pskr_req_if.sink    i_req,
    pskr_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned SET_COUNT = TABLE_ENTRIES / TABLE_WAYS;
    localparam int unsigned SET_BITS  = $clog2(SET_COUNT);
    localparam int unsigned Q_W       = $bits(t_req) + SET_BITS;

    t_cfg                r_cfg;
    logic                front_valid;
    logic                q_ready;
    t_req                front_req;
    logic [SET_BITS-1:0] front_set;
    logic                q_valid;
    logic [Q_W-1:0]      q_data;
    t_req                q_req;
    logic [SET_BITS-1:0] q_set;
    logic                back_pop;
    logic                back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length_ns        <= WINDOW_RST;
            r_cfg.max_knocks_per_window   <= KNOCKS_RST;
            r_cfg.max_sessions_per_source <= SESSIONS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW:   r_cfg.window_length_ns        <= i_cfg_data;
                CFG_KNOCKS:   r_cfg.max_knocks_per_window   <= i_cfg_data[15:0];
                CFG_SESSIONS: r_cfg.max_sessions_per_source <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    pskr_front #(.SET_COUNT(SET_COUNT), .SET_BITS(SET_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (back_busy),
        .i_req   (i_req),
        .o_valid (front_valid),
        .i_ready (q_ready),
        .o_req   (front_req),
        .o_set   (front_set)
    );

    pskr_fifo #(.WIDTH(Q_W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .o_push_ready (q_ready),
        .i_push_data  ({front_req, front_set}),
        .o_pop_valid  (q_valid),
        .i_pop        (back_pop),
        .o_pop_data   (q_data)
    );

    assign q_req = t_req'(q_data[Q_W-1:SET_BITS]);
    assign q_set = q_data[SET_BITS-1:0];

    pskr_back #(
        .TABLE_WAYS (TABLE_WAYS),
        .COUNT_BITS (COUNT_BITS),
        .SET_COUNT  (SET_COUNT),
        .SET_BITS   (SET_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_req   (q_req),
        .i_set   (q_set),
        .o_pop   (back_pop),
        .o_busy  (back_busy),
        .o_rsp   (o_rsp)
    );

endmodule
